[rtl/core/bbs_pkg.sv]
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared constants, payload types and controller/datapath links for the
// bitmap block store.
// ----------------------------------------------------------------------------
package bbs_pkg;

  localparam int MAX_BLOCKS      = 1024;
  localparam int MAX_BLOCK_BYTES = 64;
  localparam int PTR_BYTES       = 4;

  localparam int REQ_TYPE_W = 2;
  localparam int BLOCK_W    = 10;
  localparam int OFFSET_W   = 6;
  localparam int DATA_W     = 8;
  localparam int TLEN_W     = 8;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int NBLK_W     = 11;
  localparam int NBYT_W     = 7;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam int MAP_W     = 32;
  localparam int MAP_WORDS = (MAX_BLOCKS + MAP_W - 1) / MAP_W;
  localparam int MAP_AW    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(MAP_W);
  localparam int ROW_AW    = $clog2(MAX_BLOCKS);
  localparam int BYTE_AW   = $clog2(MAX_BLOCK_BYTES);
  localparam int PTR_W     = PTR_BYTES * 8;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ALLOC,
    REQ_FREE,
    REQ_WRITE,
    REQ_PTR
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOSPACE,
    ST_TOOLONG,
    ST_RANGE
  } status_t;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BLOCK_W-1:0]    block;
    logic [OFFSET_W-1:0]   byte_offset;
    logic [DATA_W-1:0]     data_byte;
    logic [TLEN_W-1:0]     text_length;
    logic [SLOT_W-1:0]     pointer_slot;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } rsp_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_PRE,
    RES_OK,
    RES_ALLOC,
    RES_NOSPACE,
    RES_PTR
  } res_sel_t;

  typedef struct packed {
    logic     clr;
    logic     load;
    logic     scan_init;
    logic     scan_next;
    logic     map_rd;
    logic     map_set;
    logic     map_clr;
    logic     st_free;
    logic     st_wr;
    logic     st_rd;
    res_sel_t res;
    logic     push;
  } bbs_cmd_t;

  typedef struct packed {
    req_kind_t op;
    logic      pre_err;
    logic      found;
    logic      last_word;
    logic      clr_last;
    logic      out_free;
  } bbs_sts_t;

endpackage

[rtl/core/bbs_regs.sv]
// ----------------------------------------------------------------------------
// bbs_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module bbs_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bbs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bbs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bbs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [bbs_pkg::NBLK_W-1:0]     blocks_in_use,
  output logic [bbs_pkg::NBYT_W-1:0]     block_bytes
);
  import bbs_pkg::*;

  typedef enum logic {
    REG_BLOCKS_IN_USE,
    REG_BLOCK_BYTES
  } reg_idx_t;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= NBLK_W'(1024);
      block_bytes   <= NBYT_W'(64);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BLOCKS_IN_USE: blocks_in_use <= pwdata[NBLK_W-1:0];
        REG_BLOCK_BYTES:   block_bytes   <= pwdata[NBYT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLOCKS_IN_USE: prdata = CFG_DATA_W'(blocks_in_use);
      REG_BLOCK_BYTES:   prdata = CFG_DATA_W'(block_bytes);
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/core/bbs_ctrl.sv]
// ----------------------------------------------------------------------------
// bbs_ctrl
// Sequencer for the block store: reset clearing sweep, request decode,
// bitmap scan and result hand-off.
// ----------------------------------------------------------------------------
module bbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bbs_pkg::bbs_sts_t sts,
  output bbs_pkg::bbs_cmd_t cmd
);
  import bbs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_MAP_RD,
    S_MAP_CHK,
    S_PTR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = RES_NONE;
    req_ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.pre_err) begin
          cmd.res    = RES_PRE;
          state_next = S_DONE;
        end else begin
          unique case (sts.op)
            REQ_ALLOC: begin
              cmd.scan_init = 1'b1;
              state_next    = S_MAP_RD;
            end
            REQ_FREE: begin
              cmd.st_free = 1'b1;
              state_next  = S_MAP_RD;
            end
            REQ_WRITE: begin
              cmd.st_wr  = 1'b1;
              cmd.res    = RES_OK;
              state_next = S_DONE;
            end
            REQ_PTR: begin
              cmd.st_rd  = 1'b1;
              state_next = S_PTR;
            end
            default: ;
          endcase
        end
      end
      S_MAP_RD: begin
        cmd.map_rd = 1'b1;
        state_next = S_MAP_CHK;
      end
      S_MAP_CHK: begin
        if (sts.op == REQ_FREE) begin
          cmd.map_clr = 1'b1;
          cmd.res     = RES_OK;
          state_next  = S_DONE;
        end else if (sts.found) begin
          cmd.map_set = 1'b1;
          cmd.res     = RES_ALLOC;
          state_next  = S_DONE;
        end else if (sts.last_word) begin
          cmd.res    = RES_NOSPACE;
          state_next = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_MAP_RD;
        end
      end
      S_PTR: begin
        cmd.res    = RES_PTR;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[rtl/core/bbs_dp.sv]
// ----------------------------------------------------------------------------
// bbs_dp
// Datapath: request register, free bitmap memory, block store memory,
// range checks, lowest-free search, pointer assembly and result registers.
// ----------------------------------------------------------------------------
module bbs_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  bbs_pkg::req_t              req,
  output bbs_pkg::rsp_t              rsp,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  logic [bbs_pkg::NBLK_W-1:0] blocks_in_use,
  input  logic [bbs_pkg::NBYT_W-1:0] block_bytes,
  input  bbs_pkg::bbs_cmd_t          cmd,
  output bbs_pkg::bbs_sts_t          sts
);
  import bbs_pkg::*;

  req_t                 r;
  logic [NBLK_W-1:0]    nblk;
  logic [NBYT_W-1:0]    nbyt;
  status_t              pre;
  logic                 blk_bad;
  logic [15:0]          slot_end;

  logic [MAP_W-1:0]     map_mem [MAP_WORDS];
  logic [MAP_W-1:0]     map_q;
  logic [MAP_AW-1:0]    scan_word;
  logic [MAP_AW-1:0]    word_addr;
  logic                 map_we;
  logic [MAP_AW-1:0]    map_waddr;
  logic [MAP_W-1:0]     map_wdata;
  logic [MAP_W-1:0]     free_vec;
  logic [BIT_W-1:0]     found_bit;
  logic                 found;
  logic                 last_word;

  logic [MAX_BLOCK_BYTES-1:0][7:0] store_mem [MAX_BLOCKS];
  logic [MAX_BLOCK_BYTES-1:0][7:0] store_q;
  logic [MAX_BLOCK_BYTES-1:0][7:0] st_wdata;
  logic [MAX_BLOCK_BYTES-1:0]      st_be;
  logic                            st_we;
  logic [ROW_AW-1:0]               st_addr;

  logic [ROW_AW-1:0]    clr_cnt;
  logic [15:0]          ptr_pos;
  logic [PTR_W-1:0]     ptr_acc;

  status_t              res_status;
  logic [VALUE_W-1:0]   res_value;

  assign nblk = (blocks_in_use > NBLK_W'(MAX_BLOCKS)) ? NBLK_W'(MAX_BLOCKS) : blocks_in_use;
  assign nbyt = (block_bytes > NBYT_W'(MAX_BLOCK_BYTES)) ? NBYT_W'(MAX_BLOCK_BYTES)
                                                         : block_bytes;

  // request register
  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
  end

  // range checks
  assign blk_bad  = NBLK_W'(r.block) >= nblk;
  assign slot_end = (16'(r.pointer_slot) + 16'd1) * 16'(PTR_BYTES);

  always_comb begin
    pre = ST_OK;
    if (r.req_type == REQ_ALLOC) begin
      if (nblk == '0) pre = ST_NOSPACE;
    end else if (blk_bad) begin
      pre = ST_RANGE;
    end else if (r.req_type == REQ_WRITE) begin
      if (NBYT_W'(r.text_length) > nbyt && r.text_length > TLEN_W'(MAX_BLOCK_BYTES)) begin
        pre = ST_TOOLONG;
      end else if (9'(r.text_length) > 9'(nbyt)) begin
        pre = ST_TOOLONG;
      end else if (NBYT_W'(r.byte_offset) >= nbyt) begin
        pre = ST_RANGE;
      end
    end else if (r.req_type == REQ_PTR) begin
      if (slot_end > 16'(nbyt)) pre = ST_RANGE;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // bitmap scan
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_word <= '0;
    end else if (cmd.scan_next) begin
      scan_word <= scan_word + 1'b1;
    end
  end

  assign word_addr = (r.req_type == REQ_ALLOC) ? scan_word : r.block[ROW_AW-1:BIT_W];

  always_comb begin
    for (int b = 0; b < MAP_W; b++) begin
      free_vec[b] = !map_q[b] && (NBLK_W'({scan_word, BIT_W'(b)}) < nblk);
    end
  end

  always_comb begin
    found_bit = '0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (free_vec[b]) found_bit = BIT_W'(b);
    end
  end

  assign found     = |free_vec;
  assign last_word = (NBLK_W'({scan_word, {BIT_W{1'b0}}}) + NBLK_W'(MAP_W)) >= nblk;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = word_addr;
    map_wdata = map_q;
    if (cmd.clr) begin
      map_we    = (NBLK_W'(clr_cnt) < NBLK_W'(MAP_WORDS));
      map_waddr = clr_cnt[MAP_AW-1:0];
      map_wdata = '0;
    end else if (cmd.map_set) begin
      map_we    = 1'b1;
      map_wdata = map_q | (MAP_W'(1) << found_bit);
    end else if (cmd.map_clr) begin
      map_we    = 1'b1;
      map_wdata = map_q & ~(MAP_W'(1) << r.block[BIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (cmd.map_rd) map_q <= map_mem[word_addr];
  end

  // block store, one row per block with byte enables
  always_comb begin
    st_we    = 1'b0;
    st_addr  = r.block[ROW_AW-1:0];
    st_be    = '0;
    st_wdata = '0;
    if (cmd.clr) begin
      st_we   = 1'b1;
      st_addr = clr_cnt;
      st_be   = '1;
    end else if (cmd.st_free) begin
      st_we = 1'b1;
      for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
        st_be[i] = NBYT_W'(i) < nbyt;
      end
    end else if (cmd.st_wr) begin
      st_we    = 1'b1;
      st_wdata = {MAX_BLOCK_BYTES{r.data_byte}};
      for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
        st_be[i] = BYTE_AW'(i) == r.byte_offset[BYTE_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
        if (st_be[i]) store_mem[st_addr][i] <= st_wdata[i];
      end
    end
    if (cmd.st_rd) store_q <= store_mem[st_addr];
  end

  // big-endian pointer assembly
  always_comb begin
    ptr_acc = '0;
    ptr_pos = '0;
    for (int i = 0; i < PTR_BYTES; i++) begin
      ptr_pos = 16'(r.pointer_slot) * 16'(PTR_BYTES) + 16'(i);
      if (ptr_pos < 16'(MAX_BLOCK_BYTES)) begin
        ptr_acc[(PTR_BYTES-1-i)*8 +: 8] = store_q[ptr_pos[BYTE_AW-1:0]];
      end
    end
  end

  // result
  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_PRE: begin
        res_status <= pre;
        res_value  <= '1;
      end
      RES_OK: begin
        res_status <= ST_OK;
        res_value  <= '0;
      end
      RES_ALLOC: begin
        res_status <= ST_OK;
        res_value  <= VALUE_W'({scan_word, found_bit});
      end
      RES_NOSPACE: begin
        res_status <= ST_NOSPACE;
        res_value  <= '1;
      end
      RES_PTR: begin
        res_status <= ST_OK;
        res_value  <= VALUE_W'(ptr_acc);
      end
      default: ;
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp.status <= res_status;
      rsp.value  <= res_value;
    end
  end

  assign sts.op        = req_kind_t'(r.req_type);
  assign sts.pre_err   = pre != ST_OK;
  assign sts.found     = found;
  assign sts.last_word = last_word;
  assign sts.clr_last  = clr_cnt == ROW_AW'(MAX_BLOCKS - 1);
  assign sts.out_free  = !rsp_valid || rsp_ready;

endmodule

[rtl/core/bitmap_block_store_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_block_store_unit
// Block store with a free bitmap: allocate, free, write byte, read pointer.
// An allocate scans the 32-bit bitmap words in turn until it finds a free
// block or reaches the last word in use.
// One request at a time; the next beat is taken in the cycle after the result
// is handed to the output register, so a waiting result does not stall it.
// After reset a clearing sweep zeroes bitmap and store;
// no request is taken during it, configuration writes are.
// ----------------------------------------------------------------------------
module bitmap_block_store_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bbs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bbs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bbs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  bbs_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output bbs_pkg::rsp_t                  rsp
);
  import bbs_pkg::*;

  logic [NBLK_W-1:0] blocks_in_use;
  logic [NBYT_W-1:0] block_bytes;
  bbs_cmd_t          cmd;
  bbs_sts_t          sts;

  bbs_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .blocks_in_use (blocks_in_use),
    .block_bytes   (block_bytes)
  );

  bbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .blocks_in_use (blocks_in_use),
    .block_bytes   (block_bytes),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

[rtl/core/bbs_chk.sv]
// ----------------------------------------------------------------------------
// bbs_chk
// Port-level checks for the block store, bound to the top level.
// ----------------------------------------------------------------------------
module bbs_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bbs_pkg::rsp_t rsp
);
  import bbs_pkg::*;

  logic [1:0] pend;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat dropped or changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pend != 2'd0)
    else $error("result beat without an accepted request");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two requests outstanding");

  a_fail_ones: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.value == '1)
    else $error("failed request without all-ones value");

  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request taken during clearing sweep");

endmodule

bind bitmap_block_store_unit bbs_chk u_bbs_chk (.*);

[dv/bitmap_block_store_unit_tb.sv]
// ----------------------------------------------------------------------------
// bitmap_block_store_unit_tb
// Self-checking bench for the bitmap block store. Requests go in through a
// valid/ready channel and the block is configured over its APB port. Every
// accepted request is run through an in-bench model of the free bitmap and
// the byte store, and each result beat is compared against the oldest
// predicted result. A short directed sequence hits field extremes, range
// and length errors, allocation exhaustion and register clamping, then
// random phases cycle through several register settings with random stalls
// on both sides, one long result hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module bitmap_block_store_unit_tb;
  import bbs_pkg::*;

  localparam int REG_BLOCKS_IN_USE = 0;
  localparam int REG_BLOCK_BYTES   = 1;
  localparam int STALL_LIMIT       = 5000;
  localparam int HOLD_CYCLES       = 400;
  localparam int TAIL_CYCLES       = 80;
  localparam int PHASE_ITEMS       = 250;

  class block_store_board;
    bit                  taken [MAX_BLOCKS];
    logic [7:0]          store [MAX_BLOCKS*MAX_BLOCK_BYTES];
    logic [NBLK_W-1:0]   blocks_reg;
    logic [NBYT_W-1:0]   bytes_reg;
    rsp_t                pending_results [$];
    req_t                pending_reqs [$];
    int                  errors;
    int                  accepted;
    int                  status_seen [4];

    function new();
      foreach (taken[i]) taken[i] = 1'b0;
      foreach (store[i]) store[i] = 8'h00;
      blocks_reg = NBLK_W'(1024);
      bytes_reg  = NBYT_W'(64);
      errors     = 0;
      accepted   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
      case (idx)
        REG_BLOCKS_IN_USE: blocks_reg = v[NBLK_W-1:0];
        REG_BLOCK_BYTES:   bytes_reg  = v[NBYT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_blocks();
      return (blocks_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_reg);
    endfunction

    function int unsigned eff_bytes();
      return (bytes_reg > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : int'(bytes_reg);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_request(req_t r);
      rsp_t        want;
      int unsigned nblk;
      int unsigned nbyt;
      int unsigned base;
      int unsigned start;
      logic [63:0] acc;
      bit          found;
      nblk  = eff_blocks();
      nbyt  = eff_bytes();
      base  = int'(r.block) * MAX_BLOCK_BYTES;
      found = 1'b0;
      want.status = ST_OK;
      want.value  = '0;
      if (req_kind_t'(r.req_type) == REQ_ALLOC) begin
        for (int i = 0; i < nblk; i++) begin
          if (!found && !taken[i]) begin
            taken[i]   = 1'b1;
            want.value = VALUE_W'(i);
            found      = 1'b1;
          end
        end
        if (!found) begin
          want.status = ST_NOSPACE;
          want.value  = '1;
        end
      end else if (r.block >= nblk) begin
        want.status = ST_RANGE;
        want.value  = '1;
      end else if (req_kind_t'(r.req_type) == REQ_FREE) begin
        taken[r.block] = 1'b0;
        for (int k = 0; k < nbyt; k++) store[base+k] = 8'h00;
      end else if (req_kind_t'(r.req_type) == REQ_WRITE) begin
        if (r.text_length > nbyt) begin
          want.status = ST_TOOLONG;
          want.value  = '1;
        end else if (r.byte_offset >= nbyt) begin
          want.status = ST_RANGE;
          want.value  = '1;
        end else begin
          store[base+r.byte_offset] = r.data_byte;
        end
      end else begin
        start = int'(r.pointer_slot) * PTR_BYTES;
        if (start + PTR_BYTES > nbyt) begin
          want.status = ST_RANGE;
          want.value  = '1;
        end else begin
          acc = '0;
          for (int k = 0; k < PTR_BYTES; k++) acc = {acc[55:0], store[base+start+k]};
          want.value = acc[VALUE_W-1:0];
        end
      end
      accepted++;
      status_seen[want.status]++;
      pending_results.push_back(want);
      pending_reqs.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      req_t r;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat status %0d value %h with nothing outstanding",
                         got.status, got.value));
      end else begin
        want = pending_results.pop_front();
        r    = pending_reqs.pop_front();
        if (got.status !== want.status)
          report($sformatf("req %0d blk %0d: status %0d, want %0d",
                           r.req_type, r.block, got.status, want.status));
        if (got.value !== want.value)
          report($sformatf("req %0d blk %0d: value %h, want %h",
                           r.req_type, r.block, got.value, want.value));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  req_valid;
  logic                  req_ready;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp;

  block_store_board sb = new();
  bit               calm;
  bit               hold_req;
  int               settings_run;

  bitmap_block_store_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (calm) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
    $display("bitmap_block_store_unit_tb NOT OK");
    $finish;
  end

  task automatic cfg_write(input int idx, input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_req(input req_t r);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 30) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  task automatic req_idle();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic drain();
    req_idle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned nblk, input int unsigned nbyt);
    drain();
    cfg_write(REG_BLOCKS_IN_USE, nblk);
    cfg_write(REG_BLOCK_BYTES, nbyt);
    settings_run++;
  endtask

  function automatic req_t mk(req_kind_t k, int unsigned blk, int unsigned off,
                              int unsigned data, int unsigned tlen, int unsigned slot);
    req_t r;
    r.req_type     = k;
    r.block        = BLOCK_W'(blk);
    r.byte_offset  = OFFSET_W'(off);
    r.data_byte    = DATA_W'(data);
    r.text_length  = TLEN_W'(tlen);
    r.pointer_slot = SLOT_W'(slot);
    return r;
  endfunction

  function automatic req_t make_item();
    req_t        r;
    logic [63:0] raw;
    int unsigned nblk;
    int unsigned nbyt;
    int unsigned roll;
    int unsigned hot;
    nblk = sb.eff_blocks();
    nbyt = sb.eff_bytes();
    raw  = {$urandom(), $urandom()};
    r    = raw[$bits(req_t)-1:0];
    if ($urandom_range(0, 99) < 12) return r;
    roll = $urandom_range(0, 99);
    if (roll < 20)      r.req_type = REQ_ALLOC;
    else if (roll < 32) r.req_type = REQ_FREE;
    else if (roll < 75) r.req_type = REQ_WRITE;
    else                r.req_type = REQ_PTR;
    hot  = (nblk < 8) ? nblk : 8;
    roll = $urandom_range(0, 99);
    if (roll < 75)      r.block = BLOCK_W'($urandom_range(0, hot - 1));
    else if (roll < 92) r.block = BLOCK_W'($urandom_range(0, nblk - 1));
    else                r.block = BLOCK_W'($urandom_range(0, MAX_BLOCKS - 1));
    if ($urandom_range(0, 9) != 0) begin
      r.byte_offset  = OFFSET_W'($urandom_range(0, nbyt - 1));
      r.text_length  = TLEN_W'($urandom_range(0, nbyt));
      r.pointer_slot = SLOT_W'($urandom_range(0, nbyt / PTR_BYTES - 1));
    end
    return r;
  endfunction

  initial begin
    int unsigned phase_blocks [8];
    int unsigned phase_bytes [8];
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_valid    = 1'b0;
    req          = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    settings_run = 1;
    phase_blocks = '{1024, 1, 16, 2047, 3, 700, 1024, 32};
    phase_bytes  = '{64, 4, 8, 127, 64, 4, 20, 36};
    phase_blocks[5] = $urandom_range(1, 1024);
    phase_bytes[5]  = $urandom_range(4, 64);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset setting, full-size blocks
    push_req(mk(REQ_ALLOC, 0, 0, 0, 0, 0));
    push_req(mk(REQ_ALLOC, 1023, 63, 255, 255, 15));
    push_req(mk(REQ_WRITE, 0, 0, 8'h00, 0, 0));
    push_req(mk(REQ_WRITE, 0, 1, 8'hFF, 64, 0));
    push_req(mk(REQ_WRITE, 0, 2, 8'h5A, 64, 15));
    push_req(mk(REQ_WRITE, 0, 3, 8'hC3, 1, 0));
    push_req(mk(REQ_WRITE, 0, 63, 8'hFF, 255, 0));
    push_req(mk(REQ_WRITE, 1023, 63, 8'hA5, 64, 0));
    push_req(mk(REQ_PTR, 0, 0, 0, 0, 0));
    push_req(mk(REQ_PTR, 1023, 0, 0, 0, 15));
    push_req(mk(REQ_FREE, 1023, 0, 0, 0, 0));
    push_req(mk(REQ_PTR, 1023, 0, 0, 0, 15));

    // directed: smallest setting
    apply_setting(1, 4);
    push_req(mk(REQ_ALLOC, 0, 0, 0, 0, 0));
    push_req(mk(REQ_WRITE, 1, 0, 8'h11, 0, 0));
    push_req(mk(REQ_WRITE, 0, 3, 8'h77, 4, 0));
    push_req(mk(REQ_WRITE, 0, 4, 8'h22, 5, 0));
    push_req(mk(REQ_WRITE, 0, 4, 8'h22, 4, 0));
    push_req(mk(REQ_PTR, 0, 0, 0, 0, 1));
    push_req(mk(REQ_PTR, 0, 0, 0, 0, 0));
    push_req(mk(REQ_FREE, 1023, 0, 0, 0, 0));
    push_req(mk(REQ_FREE, 0, 0, 0, 0, 0));
    push_req(mk(REQ_ALLOC, 0, 0, 0, 0, 0));

    // directed: registers above the block's limits
    apply_setting(2047, 127);
    push_req(mk(REQ_WRITE, 1023, 63, 8'h3C, 64, 0));
    push_req(mk(REQ_PTR, 1023, 0, 0, 0, 15));
    push_req(mk(REQ_ALLOC, 0, 0, 0, 0, 0));

    for (int p = 0; p < 8; p++) begin
      apply_setting(phase_blocks[p], phase_bytes[p]);
      calm = (p == 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 100) hold_req = 1'b1;
        if (p == 4 && n == 120) drain();
        push_req(make_item());
      end
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d requests under %0d register settings", sb.accepted, settings_run);
    $display("results: %0d ok, %0d no space, %0d too long, %0d out of range",
             sb.status_seen[ST_OK], sb.status_seen[ST_NOSPACE],
             sb.status_seen[ST_TOOLONG], sb.status_seen[ST_RANGE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bitmap_block_store_unit_tb OK");
    end else begin
      $display("bitmap_block_store_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
